// ===== design/brf_pkg.sv =====
// brf_pkg: shared types and constants for the bitplane rectangle fill block
// field widths, command codes, register indexes, size reset values and the sequencer state type
// no dependencies
package brf_pkg;

    localparam int CHUNK_BITS   = 8;
    localparam int CMD_W        = 2;
    localparam int X_W          = 10;
    localparam int Y_W          = 9;
    localparam int RC_W         = 6;
    localparam int ROW_CHUNKS_W = 7;
    localparam int ROW_COUNT_W  = 9;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 9;
    localparam int S_DATA_W     = 48;
    localparam int M_DATA_W     = 8;
    localparam int M_USER_W     = 1;

    localparam logic [CMD_W-1:0] CMD_SET  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLR  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INV  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_CHUNKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 1'b1;

    localparam logic [ROW_CHUNKS_W-1:0] ROW_CHUNKS_RST = 7'd64;
    localparam logic [ROW_COUNT_W-1:0]  ROW_COUNT_RST  = 9'd256;

    localparam logic [CHUNK_BITS-1:0] CHUNK_ALL = 8'hFF;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_WALK  = 6'b000100,
        ST_DRAIN = 6'b001000,
        ST_RDWT  = 6'b010000,
        ST_RESP  = 6'b100000
    } state_t;

endpackage

// ===== design/bitplane_rect_fill.sv =====
// bitplane_rect_fill: read-modify-write sequencer over a chunk memory
// result path: a read passes ST_RDWT, then ST_RESP; a rectangle walks its chunks in ST_WALK,
// then ST_DRAIN and ST_RESP; an empty rectangle goes straight to ST_RESP; one memory read port
// and one write port walked one chunk per cycle; throughput: one request at a time, next request
// taken the cycle after the result is registered; reset: synchronous active low aresetn, then a
// clearing pass zeroes the memory before the first request is taken; depends on brf_pkg
module bitplane_rect_fill #(
    parameter int MAX_ROWS       = 256,
    parameter int MAX_ROW_CHUNKS = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [brf_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [brf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // cmd[1:0] left_x[11:2] top_y[20:12] right_x[30:21] bottom_y[39:31] read_chunk[45:40]
    input  logic [brf_pkg::S_DATA_W-1:0]        s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // chunk_value[7:0]
    output logic [brf_pkg::M_DATA_W-1:0]        m_tdata,
    // is_read_reply[0]
    output logic [brf_pkg::M_USER_W-1:0]        m_tuser
);
    import brf_pkg::*;

    localparam int DEPTH  = MAX_ROWS * MAX_ROW_CHUNKS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CHW_A  = $clog2(MAX_ROW_CHUNKS + 1);
    localparam int CHW    = (CHW_A > ROW_CHUNKS_W) ? CHW_A : ROW_CHUNKS_W;
    localparam int RWW_A  = $clog2(MAX_ROWS + 1);
    localparam int RWW    = (RWW_A > ROW_COUNT_W) ? RWW_A : ROW_COUNT_W;
    localparam int COLW   = (CHW + 3 > X_W) ? CHW + 3 : X_W;
    localparam int CIW    = COLW - 3;

    // input fields
    logic [CMD_W-1:0] in_cmd;
    logic [X_W-1:0]   in_lx;
    logic [Y_W-1:0]   in_ty;
    logic [X_W-1:0]   in_rx;
    logic [Y_W-1:0]   in_by;
    logic [RC_W-1:0]  in_rc;

    assign in_cmd = s_tdata[1:0];
    assign in_lx  = s_tdata[11:2];
    assign in_ty  = s_tdata[20:12];
    assign in_rx  = s_tdata[30:21];
    assign in_by  = s_tdata[39:31];
    assign in_rc  = s_tdata[45:40];

    state_t                  state_reg, state_next;
    logic [ROW_CHUNKS_W-1:0] row_chunks_reg;
    logic [ROW_COUNT_W-1:0]  row_count_reg;
    logic [AW-1:0]           clr_addr_reg, clr_addr_next;
    logic [CMD_W-1:0]        op_reg, op_next;
    logic [RWW-1:0]          row_reg, row_next;
    logic [RWW-1:0]          row_end_reg, row_end_next;
    logic [CIW-1:0]          col_reg, col_next;
    logic [CIW-1:0]          first_reg, first_next;
    logic [CIW-1:0]          last_reg, last_next;
    logic [CHUNK_BITS-1:0]   smask_reg, smask_next;
    logic [CHUNK_BITS-1:0]   emask_reg, emask_next;
    logic                    rd_ok_reg, rd_ok_next;
    logic                    p_valid_reg, p_valid_next;
    logic [AW-1:0]           p_addr_reg;
    logic [CHUNK_BITS-1:0]   p_mask_reg, p_mask_next;
    logic [CHUNK_BITS-1:0]   rd_data_reg;
    logic [CHUNK_BITS-1:0]   res_val_reg, res_val_next;
    logic                    res_rd_reg, res_rd_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]     m_tdata_reg, m_tdata_next;
    logic [M_USER_W-1:0]     m_tuser_reg, m_tuser_next;

    logic [CHUNK_BITS-1:0] plane_mem [DEPTH];

    // clamping of the request against the size registers
    logic [CHW-1:0]  chunks_eff;
    logic [RWW-1:0]  rows_eff;
    logic [COLW-1:0] last_col;
    logic [COLW-1:0] rx_c;
    logic [RWW-1:0]  ty_c, by_c;
    logic            rect_empty;
    logic            read_ok;
    logic            s_acc;
    logic [AW-1:0]   walk_addr, req_addr, rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [CHUNK_BITS-1:0] wr_data, rmw_data;

    always_comb begin
        if (row_chunks_reg == '0) begin
            chunks_eff = CHW'(1);
        end else if (CHW'(row_chunks_reg) > CHW'(MAX_ROW_CHUNKS)) begin
            chunks_eff = CHW'(MAX_ROW_CHUNKS);
        end else begin
            chunks_eff = CHW'(row_chunks_reg);
        end
        if (row_count_reg == '0) begin
            rows_eff = RWW'(1);
        end else if (RWW'(row_count_reg) > RWW'(MAX_ROWS)) begin
            rows_eff = RWW'(MAX_ROWS);
        end else begin
            rows_eff = RWW'(row_count_reg);
        end
    end

    assign last_col   = COLW'({chunks_eff - CHW'(1), 3'b111});
    assign rx_c       = (COLW'(in_rx) > last_col) ? last_col : COLW'(in_rx);
    assign ty_c       = (RWW'(in_ty) > rows_eff) ? rows_eff : RWW'(in_ty);
    assign by_c       = (RWW'(in_by) > rows_eff) ? rows_eff : RWW'(in_by);
    assign rect_empty = (COLW'(in_lx) > rx_c) || (ty_c >= by_c);
    assign read_ok    = (RWW'(in_ty) < rows_eff) && (CHW'(in_rc) < chunks_eff);

    assign s_acc     = s_tvalid && s_tready;
    assign walk_addr = AW'(row_reg) * AW'(MAX_ROW_CHUNKS) + AW'(col_reg);
    assign req_addr  = AW'(in_ty) * AW'(MAX_ROW_CHUNKS) + AW'(in_rc);
    assign rd_addr   = (state_reg == ST_IDLE) ? req_addr : walk_addr;

    always_comb begin
        case (op_reg)
            CMD_SET: rmw_data = rd_data_reg | p_mask_reg;
            CMD_CLR: rmw_data = rd_data_reg & ~p_mask_reg;
            default: rmw_data = rd_data_reg ^ p_mask_reg;
        endcase
    end

    assign wr_en   = (state_reg == ST_CLEAR) || p_valid_reg;
    assign wr_addr = (state_reg == ST_CLEAR) ? clr_addr_reg : p_addr_reg;
    assign wr_data = (state_reg == ST_CLEAR) ? '0 : rmw_data;

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        op_next       = op_reg;
        row_next      = row_reg;
        row_end_next  = row_end_reg;
        col_next      = col_reg;
        first_next    = first_reg;
        last_next     = last_reg;
        smask_next    = smask_reg;
        emask_next    = emask_reg;
        rd_ok_next    = rd_ok_reg;
        p_valid_next  = 1'b0;
        p_mask_next   = p_mask_reg;
        res_val_next  = res_val_reg;
        res_rd_next   = res_rd_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_acc) begin
                    op_next      = in_cmd;
                    row_next     = ty_c;
                    row_end_next = by_c;
                    first_next   = CIW'(in_lx[X_W-1:3]);
                    col_next     = CIW'(in_lx[X_W-1:3]);
                    last_next    = rx_c[COLW-1:3];
                    smask_next   = CHUNK_ALL << in_lx[2:0];
                    emask_next   = CHUNK_ALL >> (3'd7 - rx_c[2:0]);
                    rd_ok_next   = read_ok;
                    res_val_next = '0;
                    res_rd_next  = 1'b0;
                    if (in_cmd == CMD_READ) begin
                        state_next = ST_RDWT;
                    end else if (rect_empty) begin
                        state_next = ST_RESP;
                    end else begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                p_valid_next = 1'b1;
                p_mask_next  = CHUNK_ALL;
                if (col_reg == first_reg) begin
                    p_mask_next = p_mask_next & smask_reg;
                end
                if (col_reg == last_reg) begin
                    p_mask_next = p_mask_next & emask_reg;
                    col_next    = first_reg;
                    if (row_reg + RWW'(1) == row_end_reg) begin
                        state_next = ST_DRAIN;
                    end else begin
                        row_next = row_reg + RWW'(1);
                    end
                end else begin
                    col_next = col_reg + CIW'(1);
                end
            end
            ST_DRAIN: begin
                state_next = ST_RESP;
            end
            ST_RDWT: begin
                res_val_next = rd_ok_reg ? rd_data_reg : '0;
                res_rd_next  = 1'b1;
                state_next   = ST_RESP;
            end
            ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_val_reg;
                    m_tuser_next  = res_rd_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            row_chunks_reg <= ROW_CHUNKS_RST;
            row_count_reg  <= ROW_COUNT_RST;
            p_valid_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            p_valid_reg  <= p_valid_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_ROW_CHUNKS: row_chunks_reg <= cfg_wdata[ROW_CHUNKS_W-1:0];
                    CFG_ROW_COUNT:  row_count_reg  <= cfg_wdata[ROW_COUNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        row_reg     <= row_next;
        row_end_reg <= row_end_next;
        col_reg     <= col_next;
        first_reg   <= first_next;
        last_reg    <= last_next;
        smask_reg   <= smask_next;
        emask_reg   <= emask_next;
        rd_ok_reg   <= rd_ok_next;
        p_addr_reg  <= walk_addr;
        p_mask_reg  <= p_mask_next;
        res_val_reg <= res_val_next;
        res_rd_reg  <= res_rd_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // chunk memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            plane_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= plane_mem[rd_addr];
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== design/brf_checker.sv =====
// brf_checker: port-level checks on request and result ordering, rectangle result data and output hold
// bound to bitplane_rect_fill; depends on brf_pkg for port widths
module brf_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [brf_pkg::M_DATA_W-1:0]   m_tdata,
    input logic [brf_pkg::M_USER_W-1:0]   m_tuser
);
    logic [1:0] pend_reg, pend_next;
    logic       s_acc, m_acc;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    always_comb begin
        pend_next = pend_reg;
        if (s_acc && !m_acc) begin
            pend_next = pend_reg + 2'd1;
        end else if (!s_acc && m_acc) begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // a new request only when nothing is in flight beyond a waiting result
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |-> (pend_reg == 2'd0) || (pend_reg == 2'd1 && m_tvalid))
        else $error("request taken while another is in flight");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pend_reg != 2'd0)
        else $error("result without a request");

    a_rect_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("rectangle result carries data");

    a_busy_after: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> !s_tready)
        else $error("ready right after a request");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind bitplane_rect_fill brf_checker u_brf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== sim/bitplane_rect_fill_test.sv =====
`timescale 1ns / 1ps
// bitplane_rect_fill_test: self-checking bench for the bitplane rectangle fill block
// keeps its own chunk store to predict every reply; directed edge cases, then random phases
// depends on brf_pkg and bitplane_rect_fill
module bitplane_rect_fill_test;
    import brf_pkg::*;

    localparam int ROWS       = 256;
    localparam int ROW_CHUNKS = 64;
    localparam int IDLE_LIMIT = 50000;
    localparam int LONG_HOLD  = 3000;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [X_W-1:0]   left_x;
        logic [Y_W-1:0]   top_y;
        logic [X_W-1:0]   right_x;
        logic [Y_W-1:0]   bottom_y;
        logic [RC_W-1:0]  read_chunk;
    } request_t;

    typedef struct {
        logic [CHUNK_BITS-1:0] chunk;
        logic                  is_read;
    } reply_t;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_addr;
    logic [CFG_DATA_W-1:0]   cfg_wdata;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_DATA_W-1:0]     s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_DATA_W-1:0]     m_tdata;
    logic [M_USER_W-1:0]     m_tuser;

    logic [CHUNK_BITS-1:0]   plane_model [ROWS*ROW_CHUNKS];
    logic [ROW_CHUNKS_W-1:0] row_chunks_q = ROW_CHUNKS_RST;
    logic [ROW_COUNT_W-1:0]  row_count_q  = ROW_COUNT_RST;
    reply_t                  reply_q [$];
    int                      mismatch_count = 0;
    int                      idle_cycles = 0;
    int                      hold_request = 0;
    bit                      tx_steady = 1'b0;
    bit                      rx_steady = 1'b0;

    bitplane_rect_fill #(
        .MAX_ROWS       (ROWS),
        .MAX_ROW_CHUNKS (ROW_CHUNKS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #1 aclk = ~aclk;

    function automatic int unsigned effective_size(int unsigned v, int unsigned cap);
        if (v == 0) return 1;
        return (v > cap) ? cap : v;
    endfunction

    function automatic void fill_model(request_t req);
        int unsigned chunks, rows, rx, ty, by, first_c, last_c, r, c, idx;
        logic [CHUNK_BITS-1:0] start_mask, end_mask, m;
        chunks = effective_size(row_chunks_q, ROW_CHUNKS);
        rows   = effective_size(row_count_q, ROWS);
        rx = req.right_x;
        if (rx > chunks*CHUNK_BITS - 1) rx = chunks*CHUNK_BITS - 1;
        ty = req.top_y;
        if (ty > rows) ty = rows;
        by = req.bottom_y;
        if (by > rows) by = rows;
        if (req.left_x > rx || ty >= by) return;
        first_c    = req.left_x / CHUNK_BITS;
        last_c     = rx / CHUNK_BITS;
        start_mask = CHUNK_ALL << (req.left_x % CHUNK_BITS);
        end_mask   = CHUNK_ALL >> (CHUNK_BITS - 1 - rx % CHUNK_BITS);
        for (r = ty; r < by; r++) begin
            for (c = first_c; c <= last_c; c++) begin
                m = CHUNK_ALL;
                if (c == first_c) m &= start_mask;
                if (c == last_c) m &= end_mask;
                idx = r*ROW_CHUNKS + c;
                case (req.cmd)
                    CMD_SET: plane_model[idx] = plane_model[idx] | m;
                    CMD_CLR: plane_model[idx] = plane_model[idx] & ~m;
                    default: plane_model[idx] = plane_model[idx] ^ m;
                endcase
            end
        end
    endfunction

    function automatic reply_t predict_reply(request_t req);
        reply_t rep;
        int unsigned chunks, rows;
        chunks = effective_size(row_chunks_q, ROW_CHUNKS);
        rows   = effective_size(row_count_q, ROWS);
        rep.chunk   = '0;
        rep.is_read = 1'b0;
        if (req.cmd == CMD_READ) begin
            rep.is_read = 1'b1;
            if (req.top_y < rows && req.read_chunk < chunks)
                rep.chunk = plane_model[req.top_y*ROW_CHUNKS + req.read_chunk];
        end else begin
            fill_model(req);
        end
        return rep;
    endfunction

    function automatic request_t make_request(logic [CMD_W-1:0] cmd, int lx, int ty,
                                              int rx, int by, int rc);
        request_t req;
        req.cmd        = cmd;
        req.left_x     = X_W'(lx);
        req.top_y      = Y_W'(ty);
        req.right_x    = X_W'(rx);
        req.bottom_y   = Y_W'(by);
        req.read_chunk = RC_W'(rc);
        return req;
    endfunction

    function automatic logic [CMD_W-1:0] pick_rect_op();
        case ($urandom_range(0, 2))
            0:       return CMD_SET;
            1:       return CMD_CLR;
            default: return CMD_INV;
        endcase
    endfunction

    function automatic int pick_gap(bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // mostly small rectangles and reads near the area in use, some raw noise
    function automatic request_t random_request();
        request_t req;
        int unsigned chunks, rows, r;
        chunks = effective_size(row_chunks_q, ROW_CHUNKS);
        rows   = effective_size(row_count_q, ROWS);
        req.cmd        = CMD_W'($urandom);
        req.left_x     = X_W'($urandom);
        req.top_y      = Y_W'($urandom);
        req.right_x    = X_W'($urandom);
        req.bottom_y   = Y_W'($urandom);
        req.read_chunk = RC_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 35) begin
            req.cmd        = CMD_READ;
            req.top_y      = Y_W'($urandom_range(0, (rows + 1 < 511) ? rows + 1 : 511));
            req.read_chunk = RC_W'($urandom_range(0, (chunks < 63) ? chunks : 63));
        end else if (r < 88) begin
            req.cmd      = pick_rect_op();
            req.top_y    = Y_W'($urandom_range(0, rows - 1));
            req.bottom_y = req.top_y + Y_W'($urandom_range(0, 4));
            req.left_x   = X_W'($urandom_range(0, chunks*CHUNK_BITS - 1));
            if ($urandom_range(0, 9) == 0)
                req.right_x = req.left_x - X_W'($urandom_range(0, 8));
            else
                req.right_x = req.left_x + X_W'($urandom_range(0, 24));
        end
        return req;
    endfunction

    task automatic send_request(request_t req);
        int gap;
        s_tdata  <= S_DATA_W'({req.read_chunk, req.bottom_y, req.right_x,
                               req.top_y, req.left_x, req.cmd});
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        reply_q.push_back(predict_reply(req));
        gap = pick_gap(tx_steady);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_for_replies();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (reply_q.size() != 0) @(posedge aclk);
    endtask

    task automatic configure_plane(int chunks, int count);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_ROW_CHUNKS;
        cfg_wdata <= CFG_DATA_W'(chunks);
        @(posedge aclk);
        row_chunks_q = ROW_CHUNKS_W'(chunks);
        cfg_addr  <= CFG_ROW_COUNT;
        cfg_wdata <= CFG_DATA_W'(count);
        @(posedge aclk);
        row_count_q = ROW_COUNT_W'(count);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_cleared_after_reset();
        send_request(make_request(CMD_READ, 0, 0, 0, 0, 0));
        send_request(make_request(CMD_READ, 0, 255, 0, 0, 63));
    endtask

    task automatic test_fill_and_clamp();
        send_request(make_request(CMD_SET, 0, 0, 1023, 511, 0));
        send_request(make_request(CMD_READ, 0, 255, 0, 0, 63));
        send_request(make_request(CMD_READ, 0, 511, 0, 0, 63));
        send_request(make_request(CMD_READ, 0, 300, 0, 0, 0));
        // left past right, empty row span, left beyond the row width
        send_request(make_request(CMD_CLR, 40, 0, 30, 256, 0));
        send_request(make_request(CMD_CLR, 0, 20, 1023, 20, 0));
        send_request(make_request(CMD_CLR, 1023, 0, 1023, 511, 0));
        send_request(make_request(CMD_CLR, 512, 0, 600, 1, 0));
        send_request(make_request(CMD_READ, 0, 20, 0, 0, 5));
        send_request(make_request(CMD_INV, 0, 255, 1023, 300, 0));
        send_request(make_request(CMD_READ, 0, 255, 0, 0, 63));
    endtask

    task automatic test_edge_masks();
        // start and end in one chunk
        send_request(make_request(CMD_INV, 3, 1, 5, 2, 0));
        send_request(make_request(CMD_READ, 0, 1, 0, 0, 0));
        // start bit kept, chunk before the last covered
        send_request(make_request(CMD_CLR, 5, 10, 20, 12, 0));
        send_request(make_request(CMD_READ, 0, 10, 0, 0, 0));
        send_request(make_request(CMD_READ, 0, 11, 0, 0, 1));
        send_request(make_request(CMD_READ, 0, 11, 0, 0, 2));
        send_request(make_request(CMD_CLR, 7, 30, 8, 31, 0));
        send_request(make_request(CMD_READ, 0, 30, 0, 0, 0));
        send_request(make_request(CMD_READ, 0, 30, 0, 0, 1));
        wait_for_replies();
    endtask

    task automatic test_backpressure();
        tx_steady    = 1'b1;
        hold_request = LONG_HOLD;
        repeat (12) send_request(random_request());
        tx_steady = 1'b0;
        wait_for_replies();
    endtask

    task automatic test_random_phase(int chunks, int count, int n_items);
        wait_for_replies();
        configure_plane(chunks, count);
        for (int i = 0; i < n_items; i++) begin
            if (i % 80 == 0) begin
                tx_steady = ($urandom_range(0, 3) == 0);
                rx_steady = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 59) == 0) wait_for_replies();
            send_request(random_request());
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        wait_for_replies();
    endtask

    initial begin : reply_sink
        int n;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                n = hold_request;
                hold_request = 0;
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else if (rx_steady || $urandom_range(0, 99) < 65) begin
                m_tready <= 1'b1;
            end else begin
                n = pick_gap(1'b0);
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
        end
    end

    task automatic flag_mismatch(string what, int want, int got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $time);
    endtask

    always @(posedge aclk) begin : reply_checker
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (reply_q.size() == 0) begin
                flag_mismatch("unrequested reply", 0, m_tdata);
            end else begin
                want = reply_q.pop_front();
                if (m_tdata !== want.chunk)
                    flag_mismatch("chunk_value", want.chunk, m_tdata);
                if (m_tuser[0] !== want.is_read)
                    flag_mismatch("is_read_reply", want.is_read, m_tuser[0]);
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= CFG_ROW_CHUNKS;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        foreach (plane_model[i]) plane_model[i] = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_cleared_after_reset();
        test_fill_and_clamp();
        test_edge_masks();
        test_backpressure();
        test_random_phase(64, 256, 250);
        test_random_phase(1, 1, 200);
        test_random_phase(0, 0, 150);
        test_random_phase(127, 511, 200);
        test_random_phase(8, 16, 250);
        test_random_phase(33, 100, 250);
        test_random_phase(3, 300, 200);
        test_random_phase(64, 256, 250);

        wait_for_replies();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && reply_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== bitplane_rect_fill.f =====
design/brf_pkg.sv
design/bitplane_rect_fill.sv
design/brf_checker.sv
sim/bitplane_rect_fill_test.sv
